// ===== rtl/mbrle_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrle_pkg
// Shared types and constants of the monochrome bitmap run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrle_pkg;

  // file magics, big-endian over the first four bytes
  localparam logic [31:0] MagicV1 = 32'h4461_6E4D;
  localparam logic [31:0] MagicV2 = 32'h4C69_6E53;

  // header layout
  localparam logic [4:0] CsumBytes  = 5'd26;
  localparam logic [4:0] HdrLast    = 5'd31;
  localparam logic [4:0] HdrDimDone = 5'd8;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_RAW    = 3'd1,
    PH_MAP    = 3'd2,
    PH_TYPE   = 3'd3,
    PH_LIT    = 3'd4,
    PH_COUNT  = 3'd5,
    PH_VALUE  = 3'd6,
    PH_DRAIN  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_MAGIC    = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_byte;
    logic [7:0]  repeat_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        version;
    err_e        error_code;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/mbrle_in_if.sv =====
// ----------------------------------------------------------------------------
// mbrle_in_if
// Valid/ready channel carrying one file byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbrle_in_if;
  logic               valid;
  logic               ready;
  mbrle_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbrle_out_if.sv =====
// ----------------------------------------------------------------------------
// mbrle_out_if
// Valid/ready channel carrying one decoder result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbrle_out_if;
  logic           valid;
  logic           ready;
  mbrle_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbrle_decode.sv =====
// ----------------------------------------------------------------------------
// mbrle_decode
// Per-byte decoder state: header check, scan-line map skip, packet decode.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrle_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                beat_valid_i,
  input  wire mbrle_pkg::in_beat_t beat_i,
  output logic                     res_valid_o,
  output mbrle_pkg::res_t          res_o
);

  mbrle_pkg::phase_e phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] csum_q, csum_d;
  logic [31:0] magic_q, magic_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [16:0] skip_q, skip_d;
  logic [28:0] left_q, left_d;
  logic [7:0]  run_q, run_d;

  logic [7:0]  b;
  logic        eof;
  logic [16:0] width_sum;
  logic [13:0] width_bytes;
  logic [29:0] prod;
  logic [15:0] csum_x;
  logic [7:0]  rep_sel;
  logic [7:0]  rep_clip;
  logic [28:0] left_sub;
  logic        pix_done;
  logic        clr;

  assign b   = beat_i.in_byte;
  assign eof = beat_i.end_of_file;

  // image size in bytes, from the registered dimensions
  assign width_sum   = {1'b0, width_q} + 17'd7;
  assign width_bytes = width_sum[16:3];
  assign prod        = {16'b0, width_bytes} * {14'b0, height_q};

  // header checksum contribution: even bytes are the high half of a word
  assign csum_x = hdr_cnt_q[0] ? {8'h00, b} : {b, 8'h00};

  // run clamp against the bytes still owed to the image
  assign rep_sel  = (phase_q == mbrle_pkg::PH_VALUE) ? run_q : 8'd1;
  assign rep_clip = (left_q < {21'b0, rep_sel}) ? left_q[7:0] : rep_sel;
  assign left_sub = left_q - {21'b0, rep_clip};
  assign pix_done = (left_sub == 29'd0);

  // next state and result
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    csum_d    = csum_q;
    magic_d   = magic_q;
    width_d   = width_q;
    height_d  = height_q;
    skip_d    = skip_q;
    left_d    = left_q;
    run_d     = run_q;
    clr       = 1'b0;

    res_valid_o       = 1'b0;
    res_o             = '0;
    res_o.kind        = mbrle_pkg::KIND_HEADER;
    res_o.error_code  = mbrle_pkg::ERR_NONE;

    if (beat_valid_i) begin
      case (phase_q)
        mbrle_pkg::PH_HEADER: begin
          if (hdr_cnt_q < mbrle_pkg::CsumBytes) begin
            csum_d = csum_q ^ csum_x;
          end
          if (hdr_cnt_q < 5'd4) begin
            magic_d = {magic_q[23:0], b};
          end
          if (hdr_cnt_q == 5'd4) width_d  = {width_q[15:8], b};
          if (hdr_cnt_q == 5'd5) width_d  = {b, width_q[7:0]};
          if (hdr_cnt_q == 5'd6) height_d = {height_q[15:8], b};
          if (hdr_cnt_q == 5'd7) height_d = {b, height_q[7:0]};
          if (hdr_cnt_q != mbrle_pkg::HdrLast) begin
            hdr_cnt_d = hdr_cnt_q + 5'd1;
            if (hdr_cnt_q >= mbrle_pkg::HdrDimDone) begin
              left_d = prod[28:0];
            end
            if (eof) begin
              res_valid_o      = 1'b1;
              res_o.kind       = mbrle_pkg::KIND_ERROR;
              res_o.error_code = mbrle_pkg::ERR_TRUNC;
              res_o.last       = 1'b1;
              clr              = 1'b1;
            end
          end else if (eof) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mbrle_pkg::KIND_ERROR;
            res_o.error_code = mbrle_pkg::ERR_TRUNC;
            res_o.last       = 1'b1;
            clr              = 1'b1;
          end else if (csum_d != 16'd0) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mbrle_pkg::KIND_ERROR;
            res_o.error_code = mbrle_pkg::ERR_CHECKSUM;
            res_o.last       = 1'b1;
            phase_d          = mbrle_pkg::PH_DRAIN;
          end else if (magic_q != mbrle_pkg::MagicV1 && magic_q != mbrle_pkg::MagicV2) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mbrle_pkg::KIND_ERROR;
            res_o.error_code = mbrle_pkg::ERR_MAGIC;
            res_o.last       = 1'b1;
            phase_d          = mbrle_pkg::PH_DRAIN;
          end else if (left_q == 29'd0) begin
            // empty image: header closes the file
            res_valid_o = 1'b1;
            res_o.last  = 1'b1;
            phase_d     = mbrle_pkg::PH_DRAIN;
          end else begin
            res_valid_o = 1'b1;
            if (magic_q == mbrle_pkg::MagicV1) begin
              phase_d = mbrle_pkg::PH_RAW;
            end else begin
              skip_d  = {height_q, 1'b0};
              phase_d = mbrle_pkg::PH_MAP;
            end
          end
        end
        mbrle_pkg::PH_MAP: begin
          if (eof) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mbrle_pkg::KIND_ERROR;
            res_o.error_code = mbrle_pkg::ERR_TRUNC;
            res_o.last       = 1'b1;
            clr              = 1'b1;
          end else begin
            skip_d = (skip_q != 17'd0) ? skip_q - 17'd1 : 17'd0;
            if (skip_d == 17'd0) phase_d = mbrle_pkg::PH_TYPE;
          end
        end
        mbrle_pkg::PH_TYPE: begin
          if (eof) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mbrle_pkg::KIND_ERROR;
            res_o.error_code = mbrle_pkg::ERR_TRUNC;
            res_o.last       = 1'b1;
            clr              = 1'b1;
          end else if (b != 8'd0) begin
            run_d   = b;
            phase_d = mbrle_pkg::PH_LIT;
          end else begin
            phase_d = mbrle_pkg::PH_COUNT;
          end
        end
        mbrle_pkg::PH_COUNT: begin
          if (eof) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mbrle_pkg::KIND_ERROR;
            res_o.error_code = mbrle_pkg::ERR_TRUNC;
            res_o.last       = 1'b1;
            clr              = 1'b1;
          end else begin
            run_d   = b;
            phase_d = mbrle_pkg::PH_VALUE;
          end
        end
        mbrle_pkg::PH_RAW, mbrle_pkg::PH_LIT, mbrle_pkg::PH_VALUE: begin
          if (phase_q == mbrle_pkg::PH_LIT) begin
            run_d   = (run_q != 8'd0) ? run_q - 8'd1 : 8'd0;
            if (run_d == 8'd0) phase_d = mbrle_pkg::PH_TYPE;
          end
          if (phase_q == mbrle_pkg::PH_VALUE) begin
            phase_d = mbrle_pkg::PH_TYPE;
            run_d   = 8'd0;
          end
          if (phase_q == mbrle_pkg::PH_VALUE && run_q == 8'd0) begin
            // zero repeat count consumes the value byte silently
            if (eof) begin
              res_valid_o      = 1'b1;
              res_o.kind       = mbrle_pkg::KIND_ERROR;
              res_o.error_code = mbrle_pkg::ERR_TRUNC;
              res_o.last       = 1'b1;
              clr              = 1'b1;
            end
          end else begin
            left_d      = left_sub;
            res_valid_o = 1'b1;
            if (pix_done) begin
              res_o.kind       = mbrle_pkg::KIND_PIXEL;
              res_o.pixel_byte = ~b;
              res_o.repeat_res = rep_clip;
              res_o.last       = 1'b1;
              if (eof) clr = 1'b1;
              else phase_d = mbrle_pkg::PH_DRAIN;
            end else if (eof) begin
              res_o.kind       = mbrle_pkg::KIND_ERROR;
              res_o.error_code = mbrle_pkg::ERR_TRUNC;
              res_o.last       = 1'b1;
              clr              = 1'b1;
            end else begin
              res_o.kind       = mbrle_pkg::KIND_PIXEL;
              res_o.pixel_byte = ~b;
              res_o.repeat_res = rep_clip;
            end
          end
        end
        default: begin
          // drain: ignore bytes up to the end of the file
          if (eof) clr = 1'b1;
        end
      endcase
    end

    // header values as received so far
    res_o.image_width  = width_d;
    res_o.image_height = height_d;
    res_o.version      = (magic_d == mbrle_pkg::MagicV2);

    // new file starts after every end of file
    if (clr) begin
      phase_d   = mbrle_pkg::PH_HEADER;
      hdr_cnt_d = 5'd0;
      csum_d    = 16'd0;
      magic_d   = 32'd0;
      width_d   = 16'd0;
      height_d  = 16'd0;
      skip_d    = 17'd0;
      left_d    = 29'd0;
      run_d     = 8'd0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mbrle_pkg::PH_HEADER;
      hdr_cnt_q <= 5'd0;
      csum_q    <= 16'd0;
      magic_q   <= 32'd0;
      width_q   <= 16'd0;
      height_q  <= 16'd0;
      skip_q    <= 17'd0;
      left_q    <= 29'd0;
      run_q     <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      csum_q    <= csum_d;
      magic_q   <= magic_d;
      width_q   <= width_d;
      height_q  <= height_d;
      skip_q    <= skip_d;
      left_q    <= left_d;
      run_q     <= run_d;
    end
  end

`ifndef SYNTH
  // a literal run in progress always owes at least one byte
  a_lit_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mbrle_pkg::PH_LIT |-> run_q != 8'd0)
    else $error("literal phase with empty run");

  // map skipping always has bytes left to skip
  a_map_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mbrle_pkg::PH_MAP |-> skip_q != 17'd0)
    else $error("map phase with empty skip count");

  // pixel phases always owe image bytes
  a_pix_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mbrle_pkg::PH_RAW || phase_q == mbrle_pkg::PH_LIT ||
     phase_q == mbrle_pkg::PH_VALUE) |-> left_q != 29'd0)
    else $error("pixel phase with image complete");

  // a pixel result never carries a zero repeat
  a_pix_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == mbrle_pkg::KIND_PIXEL |-> res_o.repeat_res != 8'd0)
    else $error("pixel result with zero repeat");
`endif

endmodule

`default_nettype wire

// ===== rtl/mbrle_out_buf.sv =====
// ----------------------------------------------------------------------------
// mbrle_out_buf
// Result register with a skid stage so the input side keeps flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrle_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mbrle_pkg::res_t data_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output mbrle_pkg::res_t      out_data_o,
  input  wire logic            out_ready_i
);

  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  mbrle_pkg::res_t out_q, out_d;
  mbrle_pkg::res_t skid_q, skid_d;
  logic            out_fire;

  assign out_fire    = out_valid_q && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // steer a new result into the output or the skid register
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef SYNTH
  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid valid with empty output register");

  // no new result while the skid is occupied
  a_no_push_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into full buffer");

  // skid fills only when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_valid_q ##1 skid_valid_q |-> $past(out_valid_q && !out_ready_i))
    else $error("skid filled without a stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/mono_bitmap_file_rle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_file_rle_decoder_core
// Byte-stream decoder for monochrome bitmap files, raw and run-length.
// ----------------------------------------------------------------------------
// Usage:
//  in_i carries one file byte per beat with end_of_file on the final byte.
//  out_o carries results: a header beat after byte 32, one beat per pixel
//  run (inverted byte plus repeat count), or an error beat; last marks the
//  final result of a file. Map, type and count bytes give no result.
//  Throughput is one input beat per cycle while in_i.ready is high; each result
//  is registered in the output buffer before it reaches out_o. The per-byte
//  step is a single register-to-register pass; the image size product is
//  formed in a register while the remaining header bytes stream in.
//  When out_o stalls, one more result is absorbed by a skid register, then
//  in_i.ready drops until out_o takes a beat and the skid moves up.
//  Reset clears the decoder state and the valid flags: the decoder waits for the first header byte and
//  out_o is empty. Each end_of_file returns the decoder to the header state.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_file_rle_decoder_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mbrle_in_if.sink     in_i,
  mbrle_out_if.source  out_o
);

  logic            accept;
  logic            res_valid;
  mbrle_pkg::res_t res;
  logic            buf_ready;

  assign accept     = in_i.valid && buf_ready;
  assign in_i.ready = buf_ready;

  // byte decoder
  mbrle_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (accept),
    .beat_i       (in_i.data),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register and skid
  mbrle_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .in_ready_o  (buf_ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

endmodule

`default_nettype wire
